[rtl/core/assert_macros.svh]
// assertion macros shared by the rtl
// expects a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mbps_pkg.sv]
// shared types and constants for the masked byte pattern scanner
// no dependencies
package mbps_pkg;

    localparam int MAX_PATTERN_BYTES_DEF = 32;
    localparam int ADDRESS_BITS_DEF      = 32;
    localparam int DATA_W                = 8;
    localparam int ADDR_W                = 32;
    localparam int PAT_REGS              = 4;
    localparam int PAT_REG_BYTES         = 32;
    localparam int CFG_DATA_W            = 64;
    localparam int CFG_ADDR_W            = 6;
    localparam int LEN_REG_W             = 6;
    localparam int TARGET_W              = 16;
    localparam int STATUS_W              = 2;

    typedef enum logic [2:0] {
        REG_PAT0     = 3'd0,
        REG_PAT1     = 3'd1,
        REG_PAT2     = 3'd2,
        REG_PAT3     = 3'd3,
        REG_CARE     = 3'd4,
        REG_LEN      = 3'd5,
        REG_TARGET   = 3'd6,
        REG_BACKWARD = 3'd7
    } t_reg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_MATCH    = 2'd0,
        ST_NO_MATCH = 2'd1,
        ST_INVALID  = 2'd2
    } t_status;

    typedef struct packed {
        logic [PAT_REGS*CFG_DATA_W-1:0] pattern;
        logic [PAT_REG_BYTES-1:0]       care;
        logic [LEN_REG_W-1:0]           length;
        logic [TARGET_W-1:0]            target;
        logic                           backward;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [ADDR_W-1:0] addr;
    } t_stage;

endpackage

[rtl/core/masked_byte_pattern_scanner.sv]
// Masked byte pattern scanner. Takes one byte per clock with its address and compares the
// newest bytes against a programmed pattern of up to MAX_PATTERN_BYTES bytes, with a care
// mask for wildcard positions. One result per scan: the start address of the N-th match as
// soon as it is seen, otherwise a no-match or invalid-pattern status on the tlast byte.
// Throughput is one byte per clock; a result passes through the window register and then the
// compare stage that feeds the output register. Both stages stall together only while a
// result waits on m_tready. Program the registers over apb while no scan is in flight; there
// is no clearing pass after reset.
`include "assert_macros.svh"
module masked_byte_pattern_scanner import mbps_pkg::*; #(
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
    parameter int ADDRESS_BITS      = ADDRESS_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // data_byte[7:0], byte_address[39:8]
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [ADDR_W-1:0]     m_tdata,   // match_address[31:0]
    output logic [STATUS_W-1:0]   m_tuser,   // scan_status[1:0]
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);

    t_cfg                                cfg;
    t_stage                              stage;
    logic [DATA_W*MAX_PATTERN_BYTES-1:0] win;
    logic [LEN_W-1:0]                    fill;
    logic                                advance;
    logic                                accept;

    // stall both stages only while a result waits
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    mbps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mbps_window #(
        .MAX_BYTES (MAX_PATTERN_BYTES),
        .LEN_W     (LEN_W)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_accept  (accept),
        .i_data    (s_tdata[DATA_W-1:0]),
        .i_addr    (s_tdata[DATA_W +: ADDR_W]),
        .i_last    (s_tlast),
        .o_win     (win),
        .o_fill    (fill),
        .o_stage   (stage)
    );

    mbps_match #(
        .MAX_BYTES    (MAX_PATTERN_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS),
        .LEN_W        (LEN_W)
    ) u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_cfg     (cfg),
        .i_win     (win),
        .i_fill    (fill),
        .i_stage   (stage),
        .o_valid   (m_tvalid),
        .o_status  (m_tuser),
        .o_addr    (m_tdata)
    );

    `ASSERT_SAME(a_addr_zero_unless_match, m_tvalid && (m_tuser != ST_MATCH), m_tdata == '0, "match address set on a non-match result")
    `ASSERT_SAME(a_invalid_needs_empty, m_tvalid && (m_tuser == ST_INVALID), cfg.length == '0, "invalid status with a non-empty pattern")
    `ASSERT_SAME(a_ready_when_empty, !m_tvalid, s_tready, "input stalled while the output register is empty")
    `ASSERT_NEXT(a_result_from_stage, advance && !stage.valid, !m_tvalid, "result without an item in the window stage")

endmodule

[rtl/core/mbps_regs.sv]
// configuration register file behind the apb port
// depends on mbps_pkg
module mbps_regs import mbps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [CFG_DATA_W-1:0]    r_pat [PAT_REGS];
    logic [PAT_REG_BYTES-1:0] r_care;
    logic [LEN_REG_W-1:0]     r_len;
    logic [TARGET_W-1:0]      r_target;
    logic                     r_backward;
    logic                     wr_en;
    t_reg_idx                 reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = t_reg_idx'(paddr[CFG_ADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PAT_REGS; i++) begin
                r_pat[i] <= '0;
            end
            r_care     <= '1;
            r_len      <= '0;
            r_target   <= TARGET_W'(1);
            r_backward <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PAT0:     r_pat[0]   <= pwdata;
                REG_PAT1:     r_pat[1]   <= pwdata;
                REG_PAT2:     r_pat[2]   <= pwdata;
                REG_PAT3:     r_pat[3]   <= pwdata;
                REG_CARE:     r_care     <= pwdata[PAT_REG_BYTES-1:0];
                REG_LEN:      r_len      <= pwdata[LEN_REG_W-1:0];
                REG_TARGET:   r_target   <= pwdata[TARGET_W-1:0];
                REG_BACKWARD: r_backward <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PAT0:     prdata = r_pat[0];
            REG_PAT1:     prdata = r_pat[1];
            REG_PAT2:     prdata = r_pat[2];
            REG_PAT3:     prdata = r_pat[3];
            REG_CARE:     prdata = CFG_DATA_W'(r_care);
            REG_LEN:      prdata = CFG_DATA_W'(r_len);
            REG_TARGET:   prdata = CFG_DATA_W'(r_target);
            REG_BACKWARD: prdata = CFG_DATA_W'(r_backward);
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.pattern  = {r_pat[3], r_pat[2], r_pat[1], r_pat[0]};
        o_cfg.care     = r_care;
        o_cfg.length   = r_len;
        o_cfg.target   = r_target;
        o_cfg.backward = r_backward;
    end

endmodule

[rtl/core/mbps_window.sv]
// input stage: sliding byte window, fill count and registered item fields
// depends on mbps_pkg
module mbps_window import mbps_pkg::*; #(
    parameter int MAX_BYTES = MAX_PATTERN_BYTES_DEF,
    parameter int LEN_W     = $clog2(MAX_BYTES + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_advance,
    input  logic                      i_accept,
    input  logic [DATA_W-1:0]         i_data,
    input  logic [ADDR_W-1:0]         i_addr,
    input  logic                      i_last,
    output logic [DATA_W*MAX_BYTES-1:0] o_win,
    output logic [LEN_W-1:0]          o_fill,
    output t_stage                    o_stage
);

    logic [DATA_W*MAX_BYTES-1:0] r_win;
    logic [DATA_W*MAX_BYTES-1:0] n_win;
    logic [LEN_W-1:0]            r_fill;
    logic [LEN_W-1:0]            n_fill;
    logic [LEN_W-1:0]            base_fill;
    logic                        r_clr;
    logic                        r_valid;
    logic                        r_last;
    logic [ADDR_W-1:0]           r_addr;

    // newest byte at index 0; a finished scan starts from an empty window
    always_comb begin
        n_win     = ((r_clr ? '0 : r_win) << DATA_W) | (DATA_W*MAX_BYTES)'(i_data);
        base_fill = r_clr ? '0 : r_fill;
        n_fill    = (base_fill == LEN_W'(MAX_BYTES)) ? base_fill : base_fill + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= 1'b1;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_accept;
            if (i_accept) begin
                r_clr  <= i_last;
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_accept) begin
            r_win  <= n_win;
            r_last <= i_last;
            r_addr <= i_addr;
        end
    end

    assign o_win   = r_win;
    assign o_fill  = r_fill;
    assign o_stage = {r_valid, r_last, r_addr};

endmodule

[rtl/core/mbps_match.sv]
// compare stage: masked window compare, match counting and result register
// depends on mbps_pkg
module mbps_match import mbps_pkg::*; #(
    parameter int MAX_BYTES    = MAX_PATTERN_BYTES_DEF,
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
    parameter int LEN_W        = $clog2(MAX_BYTES + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  t_cfg                        i_cfg,
    input  logic [DATA_W*MAX_BYTES-1:0] i_win,
    input  logic [LEN_W-1:0]            i_fill,
    input  t_stage                      i_stage,
    output logic                        o_valid,
    output logic [STATUS_W-1:0]         o_status,
    output logic [ADDR_W-1:0]           o_addr
);

    logic [DATA_W-1:0]           pat   [MAX_BYTES];
    logic [MAX_BYTES-1:0]        care;
    logic [MAX_BYTES-1:0]        pos_ok;
    logic [DATA_W*MAX_BYTES-1:0] rev_win;
    logic [DATA_W*MAX_BYTES-1:0] aligned;
    logic [LEN_W-1:0]            len;
    logic [LEN_W-1:0]            shamt;
    logic [LEN_REG_W:0]          plen;
    logic [ADDR_W-1:0]           fwd_start;
    logic [TARGET_W-1:0]         r_cnt;
    logic [TARGET_W-1:0]         n_cnt;
    logic [TARGET_W-1:0]         cnt_inc;
    logic                        r_done;
    logic                        n_done;
    logic                        hit;
    logic                        report;
    logic                        res_valid;
    logic [STATUS_W-1:0]         res_status;
    logic [ADDR_W-1:0]           res_addr;
    logic                        r_out_valid;
    logic [STATUS_W-1:0]         r_out_status;
    logic [ADDR_W-1:0]           r_out_addr;

    for (genvar k = 0; k < MAX_BYTES; k++) begin : g_pat
        if (k < PAT_REG_BYTES) begin : g_reg
            assign pat[k]  = i_cfg.pattern[DATA_W*k +: DATA_W];
            assign care[k] = i_cfg.care[k];
        end else begin : g_fixed
            assign pat[k]  = '0;
            assign care[k] = 1'b1;
        end
        assign rev_win[DATA_W*k +: DATA_W] = i_win[DATA_W*(MAX_BYTES-1-k) +: DATA_W];
    end

    // clamp the length to the window depth
    always_comb begin
        plen = {1'b0, i_cfg.length};
        len  = (plen > (LEN_REG_W+1)'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : LEN_W'(plen);
    end

    // ascending: pattern byte k sits len-1-k bytes back, a shift of the reversed window
    always_comb begin
        shamt   = LEN_W'(MAX_BYTES) - len;
        aligned = i_cfg.backward ? i_win : (rev_win >> {shamt, 3'b000});
        for (int k = 0; k < MAX_BYTES; k++) begin
            pos_ok[k] = (LEN_W'(k) >= len) || !care[k]
                        || (aligned[DATA_W*k +: DATA_W] == pat[k]);
        end
    end

    if (ADDRESS_BITS >= ADDR_W) begin : g_addr_wide
        logic [ADDRESS_BITS-1:0] sub;
        assign sub       = ADDRESS_BITS'(i_stage.addr) - ADDRESS_BITS'(len)
                           + ADDRESS_BITS'(1);
        assign fwd_start = sub[ADDR_W-1:0];
    end else begin : g_addr_narrow
        logic [ADDRESS_BITS-1:0] sub;
        assign sub       = i_stage.addr[ADDRESS_BITS-1:0] - ADDRESS_BITS'(len)
                           + ADDRESS_BITS'(1);
        assign fwd_start = ADDR_W'(sub);
    end

    always_comb begin
        cnt_inc = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;
        hit     = i_stage.valid && !r_done && (len != '0) && (i_fill >= len) && (&pos_ok);
        report  = hit && (i_cfg.target != '0) && (cnt_inc == i_cfg.target);
        n_cnt   = hit ? cnt_inc : r_cnt;
        n_done  = r_done | report;
        if (i_stage.last) begin
            n_cnt  = '0;
            n_done = 1'b0;
        end
        res_valid = report || (i_stage.valid && i_stage.last && !r_done);
        if (report) begin
            res_status = ST_MATCH;
            res_addr   = i_cfg.backward ? i_stage.addr : fwd_start;
        end else begin
            res_status = (len == '0) ? ST_INVALID : ST_NO_MATCH;
            res_addr   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_advance) begin
            r_out_valid <= res_valid;
            if (i_stage.valid) begin
                r_cnt  <= n_cnt;
                r_done <= n_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && res_valid) begin
            r_out_status <= res_status;
            r_out_addr   <= res_addr;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_addr   = r_out_addr;

endmodule
